### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled
// during reset on arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### src/tcpm_pkg.sv
// ----------------------------------------------------------------------------
// tcpm_pkg
// Request kinds and stream widths of the two-channel PCM mixer.
// ----------------------------------------------------------------------------
package tcpm_pkg;

	localparam int KIND_W     = 3;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 16;
	localparam int POS_W      = 15;

	localparam logic [KIND_W-1:0] KIND_TICK         = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START_MUSIC  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP_MUSIC   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_START_EFFECT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LOAD_MUSIC   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_LOAD_EFFECT  = 3'd5;

	localparam logic [7:0] LEVEL_SILENCE = 8'd128;

endpackage

### src/two_channel_pcm_mixer_pwm.sv
// ----------------------------------------------------------------------------
// two_channel_pcm_mixer_pwm
// Two-channel 8-bit PCM player with a PWM compare level output per tick.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle while the input is not
// stalled. Tick requests produce one result each: both sample memories
// are read into the read-stage registers while the channel positions
// advance, then the mix stage mixes, clamps and registers the level in
// the output register. The read stage serves the registered memory read port.
// Load requests write one memory byte and are visible to the next tick.
// MUSIC_DEPTH and EFFECT_DEPTH must be powers of two; positions are taken
// modulo the depth. Output backpressure only stalls the input once both the
// output register and the read stage hold a result.
module two_channel_pcm_mixer_pwm #(
	parameter int MUSIC_DEPTH  = 32768,
	parameter int EFFECT_DEPTH = 16384
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [15:0]                      cfg_wdata,      // music_length
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// music_loop[0], music_loud[1], effect_start[15:2], effect_length[30:16],
	// effect_stops_music[31], load_address[46:32], load_byte[54:47]
	input  logic [tcpm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [tcpm_pkg::KIND_W-1:0]      s_axis_tuser,   // kind
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pwm_level[7:0], channel_active[8]
	output logic [tcpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import tcpm_pkg::*;

	localparam int MAW = $clog2(MUSIC_DEPTH);
	localparam int EAW = $clog2(EFFECT_DEPTH);

	// Request fields.
	logic             in_music_loop;
	logic             in_music_loud;
	logic [13:0]      in_effect_start;
	logic [14:0]      in_effect_length;
	logic             in_effect_stops_music;
	logic [POS_W-1:0] in_load_address;
	logic [7:0]       in_load_byte;

	assign in_music_loop         = s_axis_tdata[0];
	assign in_music_loud         = s_axis_tdata[1];
	assign in_effect_start       = s_axis_tdata[15:2];
	assign in_effect_length      = s_axis_tdata[30:16];
	assign in_effect_stops_music = s_axis_tdata[31];
	assign in_load_address       = s_axis_tdata[46:32];
	assign in_load_byte          = s_axis_tdata[54:47];

	// Channel state.
	logic [15:0]      music_length_q;
	logic [POS_W-1:0] music_pos_q;
	logic             music_play_q;
	logic             music_rep_q;
	logic             music_loud_q;
	logic [POS_W-1:0] eff_pos_q;
	logic [POS_W-1:0] eff_end_q;
	logic             eff_play_q;

	// Read stage.
	logic             s1_valid_q;
	logic             m_act_s1;
	logic             e_act_s1;
	logic             loud_s1;
	logic [7:0]       m_rd_s1;
	logic [7:0]       e_rd_s1;

	// Output register.
	logic             out_valid_q;
	logic [7:0]       level_q;
	logic             active_q;

	logic             accept;
	logic             s1_adv;
	logic [15:0]      music_next;
	logic             music_wrap;
	logic             eff_has;

	logic [MAW+POS_W-1:0] m_rd_ext;
	logic [MAW+POS_W-1:0] m_wr_ext;
	logic [EAW+POS_W-1:0] e_rd_ext;
	logic [EAW+POS_W-1:0] e_wr_ext;
	logic [MAW-1:0]       m_rd_idx;
	logic [MAW-1:0]       m_wr_idx;
	logic [EAW-1:0]       e_rd_idx;
	logic [EAW-1:0]       e_wr_idx;

	logic [7:0] music_mem  [MUSIC_DEPTH];
	logic [7:0] effect_mem [EFFECT_DEPTH];

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;

	assign music_next = {1'b0, music_pos_q} + 16'd1;
	assign music_wrap = music_next >= music_length_q;
	assign eff_has    = eff_pos_q < eff_end_q;

	// Positions are reduced modulo the power-of-two depths by taking low bits.
	assign m_rd_ext = {{MAW{1'b0}}, music_pos_q};
	assign m_wr_ext = {{MAW{1'b0}}, in_load_address};
	assign e_rd_ext = {{EAW{1'b0}}, eff_pos_q};
	assign e_wr_ext = {{EAW{1'b0}}, in_load_address};
	assign m_rd_idx = m_rd_ext[MAW-1:0];
	assign m_wr_idx = m_wr_ext[MAW-1:0];
	assign e_rd_idx = e_rd_ext[EAW-1:0];
	assign e_wr_idx = e_wr_ext[EAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_length_q <= '0;
		end else if (cfg_we) begin
			music_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_pos_q  <= '0;
			music_play_q <= 1'b0;
			music_rep_q  <= 1'b1;
			music_loud_q <= 1'b1;
			eff_pos_q    <= '0;
			eff_end_q    <= '0;
			eff_play_q   <= 1'b0;
		end else if (accept) begin
			case (s_axis_tuser)
				KIND_TICK: begin
					if (music_play_q) begin
						if (music_wrap && music_rep_q) begin
							music_pos_q <= '0;
						end else begin
							music_pos_q <= music_next[POS_W-1:0];
						end
						if (music_wrap && !music_rep_q) begin
							music_play_q <= 1'b0;
						end
					end
					if (eff_play_q) begin
						if (eff_has) begin
							eff_pos_q <= eff_pos_q + 15'd1;
						end else begin
							eff_play_q <= 1'b0;
						end
					end
				end
				KIND_START_MUSIC: begin
					music_pos_q  <= '0;
					music_rep_q  <= in_music_loop;
					music_loud_q <= in_music_loud;
					music_play_q <= 1'b1;
				end
				KIND_STOP_MUSIC: begin
					music_play_q <= 1'b0;
				end
				KIND_START_EFFECT: begin
					if (in_effect_stops_music) begin
						music_play_q <= 1'b0;
					end
					eff_pos_q  <= {1'b0, in_effect_start};
					eff_end_q  <= {1'b0, in_effect_start} + in_effect_length;
					eff_play_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Sample memories: one write and one registered read per cycle each, on accepted requests only.
	always_ff @(posedge clk) begin
		if (accept && s_axis_tuser == KIND_LOAD_MUSIC) begin
			music_mem[m_wr_idx] <= in_load_byte;
		end
		if (accept) begin
			m_rd_s1 <= music_mem[m_rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_axis_tuser == KIND_LOAD_EFFECT) begin
			effect_mem[e_wr_idx] <= in_load_byte;
		end
		if (accept) begin
			e_rd_s1 <= effect_mem[e_rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= s_axis_tuser == KIND_TICK;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_act_s1 <= music_play_q;
			e_act_s1 <= eff_play_q && eff_has;
			loud_s1  <= music_loud_q;
		end
	end

	// Mix stage.
	logic signed [8:0] m_cen;
	logic signed [8:0] e_cen;
	logic signed [8:0] m_scl;
	logic signed [8:0] e_scl;
	logic signed [9:0] mix_sum;
	logic        [7:0] mix_level;
	logic              mix_active;
	logic        [7:0] level_next;

	always_comb begin
		m_cen = $signed({1'b0, m_rd_s1}) - 9'sd128;
		e_cen = $signed({1'b0, e_rd_s1}) - 9'sd128;
		m_scl = '0;
		e_scl = '0;
		if (m_act_s1) begin
			m_scl = loud_s1 ? (m_cen >>> 2) : (m_cen >>> 3);
		end
		if (e_act_s1) begin
			e_scl = e_cen >>> 2;
		end
		mix_sum = 10'(m_scl) + 10'(e_scl) + 10'sd128;
		if (mix_sum < 10'sd0) begin
			mix_level = 8'd0;
		end else if (mix_sum > 10'sd255) begin
			mix_level = 8'd255;
		end else begin
			mix_level = mix_sum[7:0];
		end
		mix_active = m_act_s1 || e_act_s1;
		// With both channels idle the level drifts one step toward silence.
		if (mix_active) begin
			level_next = mix_level;
		end else if (level_q > LEVEL_SILENCE) begin
			level_next = level_q - 8'd1;
		end else if (level_q < LEVEL_SILENCE) begin
			level_next = level_q + 8'd1;
		end else begin
			level_next = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			level_q     <= LEVEL_SILENCE;
			active_q    <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
			level_q     <= level_next;
			active_q    <= mix_active;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, active_q, level_q};

endmodule

### src/tcpm_checker.sv
// ----------------------------------------------------------------------------
// tcpm_checker
// Port-level checks of the PCM mixer stream behavior, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcpm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [tcpm_pkg::KIND_W-1:0]     s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [tcpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tcpm_pkg::*;

	logic tick_acc;
	logic out_stall;

	assign tick_acc  = s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_TICK;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped")
	`ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "result changed")

	// A fresh result always comes from an accepted tick.
	`ASSERT_IMPL(a_tick_origin, $rose(m_axis_tvalid), $past(tick_acc, 2), "result without tick")

	// The input only stalls when a finished result is held back.
	`ASSERT_IMPL(a_stall_cause, !s_axis_tready, out_stall, "input stalled")

endmodule

bind two_channel_pcm_mixer_pwm tcpm_checker u_tcpm_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-channel PCM mixer. Requests are planned
// into a queue, driven with random gaps and checked against an in-bench
// model of both channels and the PWM level; results are taken with random
// and long stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import tcpm_pkg::*;

	localparam int MUSIC_DEPTH   = 32768;
	localparam int EFFECT_DEPTH  = 16384;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int HOLD_PERIOD   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 203;

	localparam logic [KIND_W-1:0] KIND_RESERVED_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RESERVED_7 = 3'd7;
	localparam logic [1:0]        SHIFT_LOUD      = 2'd2;
	localparam logic [1:0]        SHIFT_SOFT      = 2'd3;
	localparam logic [1:0]        SHIFT_EFFECT    = 2'd2;

	// Request payload, last field in the lowest bits.
	typedef struct packed {
		logic          pad;
		logic [7:0]    load_byte;
		logic [14:0]   load_address;
		logic          stops_music;
		logic [14:0]   effect_length;
		logic [13:0]   effect_start;
		logic          music_loud;
		logic          music_loop;
	} req_fields_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		req_fields_t       f;
	} req_t;

	typedef struct packed {
		logic       active;
		logic [7:0] level;
	} tick_result_t;

	typedef struct packed {
		logic [POS_W-1:0] music_pos;
		logic             music_playing;
		logic             music_repeat;
		logic [1:0]       music_shift;
		logic [POS_W-1:0] effect_pos;
		logic [POS_W-1:0] effect_end;
		logic             effect_playing;
		logic [7:0]       level;
		logic             active;
	} mixer_state_t;

	localparam mixer_state_t RESET_STATE = '{
		music_pos: '0, music_playing: 1'b0, music_repeat: 1'b1, music_shift: SHIFT_LOUD,
		effect_pos: '0, effect_end: '0, effect_playing: 1'b0,
		level: LEVEL_SILENCE, active: 1'b0};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [15:0]           cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]     s_axis_tuser = KIND_TICK;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	req_t          pending_requests[$];
	tick_result_t  expected_levels[$];

	// Planning copy of the mixer, used to keep playback on written samples.
	mixer_state_t  plan_state = RESET_STATE;
	logic [15:0]   plan_len = '0;
	bit            music_written [MUSIC_DEPTH];
	bit            effect_written [EFFECT_DEPTH];
	int            item_count = 0;

	// Checking copy of the mixer, advanced on accepted requests.
	mixer_state_t  live_state;
	mixer_state_t  tick_next;
	logic [15:0]   live_len;
	logic [7:0]    music_store [MUSIC_DEPTH];
	logic [7:0]    effect_store [EFFECT_DEPTH];
	req_fields_t   acc_fields;

	req_t          tx_req;
	int            tx_gap;
	logic          tx_burst;
	logic [2:0]    rx_wait;
	logic [2:0]    rx_next;
	logic          rx_burst;
	logic          rx_hold;
	int            hold_timer;
	int            cycle_count = 0;
	int            mismatches = 0;
	tick_result_t  want;
	logic [15:0]   phase_len [RANDOM_PHASES];

	two_channel_pcm_mixer_pwm u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Sample byte made signed and shifted; >>> on int rounds toward minus infinity.
	function automatic int centered_sample(logic [7:0] b, logic [1:0] sh);
		int v;
		v = int'(b) - 128;
		return v >>> sh;
	endfunction

	function automatic mixer_state_t mix_tick(mixer_state_t s, logic [15:0] len,
			logic [7:0] m_byte, logic [7:0] e_byte);
		mixer_state_t n;
		int m, e, t, next_pos;
		n = s;
		m = 0;
		e = 0;
		n.active = 1'b0;
		if (s.music_playing) begin
			m = centered_sample(m_byte, s.music_shift);
			next_pos = int'(s.music_pos) + 1;
			n.active = 1'b1;
			if (next_pos >= int'(len)) begin
				if (s.music_repeat)
					next_pos = 0;
				else
					n.music_playing = 1'b0;
			end
			n.music_pos = next_pos[POS_W-1:0];
		end
		if (s.effect_playing) begin
			if (s.effect_pos < s.effect_end) begin
				e = centered_sample(e_byte, SHIFT_EFFECT);
				n.effect_pos = s.effect_pos + 15'd1;
				n.active = 1'b1;
			end else begin
				// The effect spends one extra tick going idle.
				n.effect_playing = 1'b0;
			end
		end
		if (n.active) begin
			t = m + e + 128;
			if (t > 255)
				t = 255;
			if (t < 0)
				t = 0;
			n.level = 8'(t);
		end else if (s.level > LEVEL_SILENCE) begin
			n.level = s.level - 8'd1;
		end else if (s.level < LEVEL_SILENCE) begin
			n.level = s.level + 8'd1;
		end
		return n;
	endfunction

	function automatic mixer_state_t apply_command(mixer_state_t s, logic [KIND_W-1:0] kind,
			req_fields_t f);
		mixer_state_t n;
		n = s;
		case (kind)
		KIND_START_MUSIC: begin
			n.music_pos = '0;
			n.music_repeat = f.music_loop;
			n.music_shift = f.music_loud ? SHIFT_LOUD : SHIFT_SOFT;
			n.music_playing = 1'b1;
		end
		KIND_STOP_MUSIC: n.music_playing = 1'b0;
		KIND_START_EFFECT: begin
			if (f.stops_music)
				n.music_playing = 1'b0;
			n.effect_pos = {1'b0, f.effect_start};
			n.effect_end = {1'b0, f.effect_start} + f.effect_length;
			n.effect_playing = 1'b1;
		end
		default: ;
		endcase
		return n;
	endfunction

	function automatic req_t random_req(logic [KIND_W-1:0] kind);
		req_t r;
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		r.kind = kind;
		r.f = bits[IN_DATA_W-1:0];
		r.f.pad = 1'b0;
		return r;
	endfunction

	task automatic push_req(req_t r);
		if (r.kind == KIND_LOAD_MUSIC)
			music_written[r.f.load_address] = 1'b1;
		else if (r.kind == KIND_LOAD_EFFECT)
			effect_written[r.f.load_address[13:0]] = 1'b1;
		else if (r.kind == KIND_TICK)
			plan_state = mix_tick(plan_state, plan_len, 8'h00, 8'h00);
		else
			plan_state = apply_command(plan_state, r.kind, r.f);
		if (r.kind != KIND_RESERVED_6 && r.kind != KIND_RESERVED_7)
			item_count++;
		pending_requests.push_back(r);
	endtask

	task automatic send_load(logic [KIND_W-1:0] kind, logic [14:0] addr, logic [7:0] data);
		req_t r;
		r = random_req(kind);
		r.f.load_address = addr;
		r.f.load_byte = data;
		push_req(r);
	endtask

	task automatic send_music(logic loop_on, logic loud);
		req_t r;
		r = random_req(KIND_START_MUSIC);
		r.f.music_loop = loop_on;
		r.f.music_loud = loud;
		push_req(r);
	endtask

	task automatic send_effect(logic [13:0] start, logic [14:0] len, logic stops);
		req_t r;
		r = random_req(KIND_START_EFFECT);
		r.f.effect_start = start;
		r.f.effect_length = len;
		r.f.stops_music = stops;
		push_req(r);
	endtask

	// Each tick first loads any sample it would read that was never written.
	task automatic send_ticks(int n);
		logic [14:0] addr;
		repeat (n) begin
			if (plan_state.music_playing && !music_written[plan_state.music_pos])
				send_load(KIND_LOAD_MUSIC, plan_state.music_pos, 8'($urandom));
			if (plan_state.effect_playing && plan_state.effect_pos < plan_state.effect_end &&
					!effect_written[plan_state.effect_pos[13:0]]) begin
				addr = plan_state.effect_pos;
				addr[14] = 1'($urandom);
				send_load(KIND_LOAD_EFFECT, addr, 8'($urandom));
			end
			push_req(random_req(KIND_TICK));
		end
	endtask

	task automatic random_phase(int budget);
		int stop_at, sel, n, k;
		logic [13:0] start;
		stop_at = item_count + budget;
		while (item_count < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				send_ticks(1);
			end else if (sel < 52) begin
				send_ticks($urandom_range(2, 24));
			end else if (sel < 60) begin
				// A short effect clip: load it, start it and play it out.
				n = $urandom_range(1, 10);
				start = 14'($urandom);
				for (k = 0; k < n; k++)
					send_load(KIND_LOAD_EFFECT, {1'($urandom), start + 14'(k)}, 8'($urandom));
				send_effect(start, 15'(n), 1'($urandom));
				send_ticks(n + $urandom_range(1, 3));
			end else if (sel < 66) begin
				n = (plan_len == 16'd0) ? 1 : ((plan_len > 16'd16) ? 16 : int'(plan_len));
				for (k = 0; k < n; k++)
					send_load(KIND_LOAD_MUSIC, 15'(k), 8'($urandom));
				send_music(1'($urandom), 1'($urandom));
				send_ticks(n + $urandom_range(0, 8));
			end else if (sel < 70) begin
				push_req(random_req(KIND_STOP_MUSIC));
			end else if (sel < 73) begin
				send_effect(14'($urandom), 15'($urandom_range(0, 24)), 1'($urandom));
			end else if (sel < 76) begin
				send_effect(14'($urandom), 15'($urandom), 1'($urandom));
			end else if (sel < 84) begin
				send_load(KIND_LOAD_MUSIC, 15'($urandom), 8'($urandom));
			end else if (sel < 92) begin
				send_load(KIND_LOAD_EFFECT, 15'($urandom), 8'($urandom));
			end else if (sel < 96) begin
				send_music(1'($urandom), 1'($urandom));
			end else begin
				push_req(random_req(sel < 98 ? KIND_RESERVED_6 : KIND_RESERVED_7));
			end
		end
	endtask

	task automatic wait_for_quiet();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_levels.size() != 0)
			@(negedge clk);
	endtask

	// Only written with the block idle, so the last request has fully drained.
	task automatic set_music_length(logic [15:0] v);
		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		plan_len = v;
		@(negedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		set_music_length(16'd3);
		send_load(KIND_LOAD_MUSIC, 15'd0, 8'h00);
		send_load(KIND_LOAD_MUSIC, 15'd1, 8'hFF);
		send_load(KIND_LOAD_MUSIC, 15'd2, 8'h80);
		// Addresses above the effect store wrap onto its low entries.
		send_load(KIND_LOAD_EFFECT, 15'h4000, 8'hFF);
		send_load(KIND_LOAD_EFFECT, 15'h3FFF, 8'h00);
		send_ticks(1);
		send_music(1'b0, 1'b1);
		send_ticks(4);
		send_effect(14'h3FFF, 15'd2, 1'b0);
		send_ticks(3);
		send_music(1'b1, 1'b0);
		send_ticks(4);
		// A zero-length effect that also stops the music.
		send_effect(14'd0, 15'd0, 1'b1);
		send_ticks(1);
		// The end wraps below the start, so the effect goes idle at once.
		send_effect(14'h3FFF, 15'h7FFF, 1'b0);
		send_ticks(1);
		push_req(random_req(KIND_RESERVED_6));
		push_req(random_req(KIND_RESERVED_7));

		phase_len = '{16'd0, 16'd1, 16'd32768, 16'hFFFF, 16'd32767, 16'd2, 16'd0, 16'd0};
		phase_len[6] = 16'($urandom_range(3, 64));
		phase_len[7] = 16'($urandom);
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_music_length(phase_len[p]);
			random_phase(PHASE_ITEMS);
		end

		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= KIND_TICK;
			tx_gap <= 0;
			tx_burst <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (pending_requests.size() != 0) begin
				tx_req = pending_requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= tx_req.f;
				s_axis_tuser <= tx_req.kind;
				tx_gap <= tx_burst ? 0 : $urandom_range(0, 7);
				if ($urandom_range(0, 39) == 0)
					tx_burst <= !tx_burst;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_state <= RESET_STATE;
			live_len <= '0;
		end else begin
			if (cfg_we)
				live_len <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				acc_fields = s_axis_tdata;
				case (s_axis_tuser)
				KIND_TICK: begin
					tick_next = mix_tick(live_state, live_len, music_store[live_state.music_pos],
						effect_store[live_state.effect_pos[13:0]]);
					live_state <= tick_next;
					expected_levels.push_back({tick_next.active, tick_next.level});
				end
				KIND_LOAD_MUSIC: music_store[acc_fields.load_address] <= acc_fields.load_byte;
				KIND_LOAD_EFFECT: effect_store[acc_fields.load_address[13:0]] <= acc_fields.load_byte;
				default: live_state <= apply_command(live_state, s_axis_tuser, acc_fields);
				endcase
			end
		end
	end

	// Long periodic receiver hold, so the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_timer <= 0;
			rx_hold <= 1'b0;
		end else begin
			hold_timer <= (hold_timer == HOLD_PERIOD - 1) ? 0 : hold_timer + 1;
			rx_hold <= (hold_timer >= HOLD_PERIOD - HOLD_CYCLES);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= '0;
			rx_burst <= 1'b0;
		end else begin
			rx_next = (rx_wait != 3'd0) ? rx_wait - 3'd1 : 3'd0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_levels.size() == 0) begin
					if (mismatches < 10)
						$display("mismatch: result with no tick pending, got level %0d active %0b",
							m_axis_tdata[7:0], m_axis_tdata[8]);
					mismatches++;
				end else begin
					want = expected_levels.pop_front();
					if (m_axis_tdata[7:0] != want.level || m_axis_tdata[8] != want.active) begin
						if (mismatches < 10)
							$display("mismatch: level %0d active %0b expected, got %0d active %0b",
								want.level, want.active, m_axis_tdata[7:0], m_axis_tdata[8]);
						mismatches++;
					end
				end
				rx_next = rx_burst ? 3'd0 : 3'($urandom_range(0, 7));
				if ($urandom_range(0, 39) == 0)
					rx_burst <= !rx_burst;
			end
			rx_wait <= rx_next;
			m_axis_tready <= (rx_next == 3'd0) && !rx_hold;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

### two_channel_pcm_mixer_pwm.f
+incdir+src
src/tcpm_pkg.sv
src/two_channel_pcm_mixer_pwm.sv
src/tcpm_checker.sv
bench/tb_top.sv
